[design/dfms_pkg.sv]
// Package for the dot field motion step unit: payload structs, register indexes.
// No dependencies.
package dfms_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRadius  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCenterX = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCenterY = 2'd2;

  // Root unit: one result bit per stage over a 62-bit radicand.
  localparam int unsigned SqrtBits = 31;

  // Sideband carried beside the root unit:
  // cos, sin, outside, last, x base, y base, re-entry y, lead.
  localparam int unsigned SideW = 162;

  // Accept edge to result strobe: 4 front + 31 root + 4 back stages.
  localparam int unsigned PipeDepth = 39;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] step_x;
    logic signed [31:0] step_y;
    logic [30:0]        step_len;
    logic signed [15:0] cos_dir;
    logic signed [15:0] sin_dir;
    logic [15:0]        rand_u;
    logic [15:0]        rand_v;
    logic               last_dot;
  } dot_req_t;

  typedef struct packed {
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic               respawned;
    logic               frame_done;
  } dot_res_t;

  // Saturate a 34-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    if (v < lo) return 32'sh8000_0000;
    return v[31:0];
  endfunction

endpackage

[design/dfms_sqrt.sv]
// Pipelined bit-serial integer square root: one result bit per stage.
// Uses dfms_pkg. Sideband travels with the data.
module dfms_sqrt (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [2*dfms_pkg::SqrtBits-1:0]    arg_i,
  input  logic [dfms_pkg::SideW-1:0]         side_i,
  output logic                               valid_o,
  output logic [dfms_pkg::SqrtBits-1:0]      root_o,
  output logic [dfms_pkg::SideW-1:0]         side_o
);
  localparam int unsigned N = dfms_pkg::SqrtBits;

  logic [N:0]                      vld;
  logic [2*N-1:0]                  rem  [N+1];
  logic [N-1:0]                    root [N+1];
  logic [dfms_pkg::SideW-1:0]      side [N+1];

  assign rem[0]  = arg_i;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign vld[0]  = valid_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Sh = 2 * (N - 1 - k);
    logic [2*N-1:0] trial;
    logic [2*N-1:0] rem_d;
    logic [N-1:0]   root_d;
    always_comb begin
      // trial = (4*root + 1) << Sh
      trial  = ({{N{1'b0}}, root[k]} << (Sh + 2)) | ({{(2*N-1){1'b0}}, 1'b1} << Sh);
      rem_d  = rem[k];
      root_d = {root[k][N-2:0], 1'b0};
      if (rem[k] >= trial) begin
        rem_d  = rem[k] - trial;
        root_d = {root[k][N-2:0], 1'b1};
      end
    end
    logic                       v_q;
    logic [2*N-1:0]             rem_q;
    logic [N-1:0]               root_q;
    logic [dfms_pkg::SideW-1:0] side_q;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else begin
        v_q <= vld[k];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      side_q <= side[k];
    end
    assign vld[k+1]  = v_q;
    assign rem[k+1]  = rem_q;
    assign root[k+1] = root_q;
    assign side[k+1] = side_q;
  end

  assign valid_o = vld[N];
  assign root_o  = root[N];
  assign side_o  = side[N];
endmodule

[design/dfms_front.sv]
// Front stages: move the dot, inside test, re-entry y, y*y, lead, radicand.
// Uses dfms_pkg.
module dfms_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  input  dfms_pkg::dot_req_t         req_i,
  input  logic [30:0]                radius_i,
  input  logic signed [31:0]         cx_i,
  input  logic signed [31:0]         cy_i,
  output logic                       valid_o,
  output logic [61:0]                arg_o,
  output logic [dfms_pkg::SideW-1:0] side_o
);
  // stage 1: moved position and offsets
  logic               v1_q;
  logic signed [31:0] px1_q, py1_q;
  logic signed [33:0] dx1_q, dy1_q;
  logic [30:0]        r1_q, len1_q;
  logic signed [15:0] c1_q, s1_q;
  logic [15:0]        u1_q, w1_q;
  logic               l1_q;
  logic signed [31:0] cx1_q, cy1_q;

  logic signed [31:0] px_d, py_d;
  always_comb begin
    px_d = dfms_pkg::sat32(34'(req_i.pos_x) + 34'(req_i.step_x));
    py_d = dfms_pkg::sat32(34'(req_i.pos_y) + 34'(req_i.step_y));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end
  always_ff @(posedge clk_i) begin
    px1_q <= px_d;
    py1_q <= py_d;
    dx1_q <= 34'(px_d) - 34'(cx_i);
    dy1_q <= 34'(py_d) - 34'(cy_i);
    r1_q <= radius_i; len1_q <= req_i.step_len;
    c1_q <= req_i.cos_dir; s1_q <= req_i.sin_dir;
    u1_q <= req_i.rand_u; w1_q <= req_i.rand_v;
    l1_q <= req_i.last_dot;
    cx1_q <= cx_i; cy1_q <= cy_i;
  end

  // stage 2: magnitudes, box test, squares, products of random fractions
  logic [33:0] mx_d, my_d;
  always_comb begin
    mx_d = dx1_q[33] ? 34'(-dx1_q) : 34'(dx1_q);
    my_d = dy1_q[33] ? 34'(-dy1_q) : 34'(dy1_q);
  end

  logic               v2_q, box2_q;
  logic [63:0]        xx2_q, yy2_q;
  logic [61:0]        rr2_q;
  logic [47:0]        uy2_q, lead2_q;
  logic signed [31:0] px2_q, py2_q, cx2_q, cy2_q;
  logic [30:0]        r2_q;
  logic signed [15:0] c2_q, s2_q;
  logic               l2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) begin
    box2_q <= (mx_d > 34'(r1_q)) || (my_d > 34'(r1_q));
    // inside the box each magnitude fits in 32 bits
    xx2_q  <= 64'(mx_d[31:0]) * 64'(mx_d[31:0]);
    yy2_q  <= 64'(my_d[31:0]) * 64'(my_d[31:0]);
    rr2_q  <= 62'(r1_q) * 62'(r1_q);
    uy2_q  <= 48'(u1_q) * 48'({r1_q, 1'b0});
    lead2_q <= 48'(w1_q) * 48'(len1_q);
    px2_q <= px1_q; py2_q <= py1_q; cx2_q <= cx1_q; cy2_q <= cy1_q;
    r2_q <= r1_q; c2_q <= c1_q; s2_q <= s1_q; l2_q <= l1_q;
  end

  // stage 3: circle test and re-entry y
  logic signed [32:0] y1_d;
  assign y1_d = 33'(uy2_q[47:16]) - 33'(r2_q);

  logic               v3_q, out3_q;
  logic [62:0]        ss3_q;
  logic [61:0]        rr3_q;
  logic signed [32:0] y3_q;
  logic [31:0]        lead3_q;
  logic signed [31:0] px3_q, py3_q, cx3_q, cy3_q;
  logic signed [15:0] c3_q, s3_q;
  logic               l3_q, box3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end
  always_ff @(posedge clk_i) begin
    ss3_q  <= 63'(xx2_q) + 63'(yy2_q);
    box3_q <= box2_q;
    rr3_q  <= rr2_q;
    y3_q   <= y1_d;
    lead3_q <= lead2_q[47:16];
    px3_q <= px2_q; py3_q <= py2_q; cx3_q <= cx2_q; cy3_q <= cy2_q;
    c3_q <= c2_q; s3_q <= s2_q; l3_q <= l2_q;
  end
  assign out3_q = box3_q || (ss3_q > 63'(rr3_q));

  // stage 4: y*y and radicand
  logic [31:0] my3;
  assign my3 = y3_q[32] ? 32'(-y3_q) : 32'(y3_q);

  logic                       v4_q;
  logic [63:0]                yy4_q;
  logic [61:0]                rr4_q;
  logic [dfms_pkg::SideW-1:0] side4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end
  always_ff @(posedge clk_i) begin
    yy4_q <= 64'(my3) * 64'(my3);
    rr4_q <= rr3_q;
    // saturated coords (px/py) are unused when respawning, so pack a
    // selected pair: position if staying, centre otherwise.
    side4_q <= {c3_q, s3_q, out3_q, l3_q,
                out3_q ? cx3_q : px3_q, out3_q ? cy3_q : py3_q,
                y3_q[31:0], lead3_q[31:0]};
  end

  assign valid_o = v4_q;
  assign arg_o   = (64'(rr4_q) > yy4_q) ? 62'(64'(rr4_q) - yy4_q) : '0;
  assign side_o  = side4_q;
endmodule

[design/dot_field_motion_step_unit.sv]
// Top level of the dot field motion step unit: config registers and pipeline.
// Uses dfms_pkg, dfms_front, dfms_sqrt.
//
//  channel  | ports                                | handshake
//  request  | start_i, busy_o, req_i               | taken when start_i & !busy_o
//  result   | res_valid_o, res_o                   | one-cycle strobe, no stall
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i      | written when cfg_we_i
//
// Fully pipelined: one request per cycle, through 4 front stages, 31 root
// stages and 4 rotate/output stages; the root unit
// sets the depth. busy_o is always low. Reset clears all valid bits and the
// registers to radius 1.0, centre 0. Results cannot be held off.
module dot_field_motion_step_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  dfms_pkg::dot_req_t   req_i,
  output logic                 res_valid_o,
  output dfms_pkg::dot_res_t   res_o,
  input  logic                 cfg_we_i,
  input  logic [dfms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_data_i
);
  logic [30:0]        radius_q;
  logic signed [31:0] cx_q, cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= 31'd65536;
      cx_q     <= '0;
      cy_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dfms_pkg::CfgRadius:  radius_q <= cfg_data_i[30:0];
        dfms_pkg::CfgCenterX: cx_q     <= cfg_data_i;
        dfms_pkg::CfgCenterY: cy_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign busy_o = 1'b0;
  logic accept;
  assign accept = start_i && !busy_o;

  // front sideband carries trig and everything the back end needs
  logic                       fv;
  logic [61:0]                farg;
  logic [dfms_pkg::SideW-1:0] fside;

  dfms_front u_front (
    .clk_i, .rst_ni,
    .valid_i (accept),
    .req_i,
    .radius_i(radius_q),
    .cx_i    (cx_q),
    .cy_i    (cy_q),
    .valid_o (fv),
    .arg_o   (farg),
    .side_o  (fside)
  );

  logic                       sv;
  logic [30:0]                root;
  logic [dfms_pkg::SideW-1:0] sside;

  dfms_sqrt u_sqrt (
    .clk_i, .rst_ni,
    .valid_i(fv),
    .arg_i  (farg),
    .side_i (fside),
    .valid_o(sv),
    .root_o (root),
    .side_o (sside)
  );

  // unpack sideband
  logic signed [15:0] cs, sn;
  logic               outside, last;
  logic signed [31:0] ax, ay, y1, lead;
  assign {cs, sn, outside, last, ax, ay, y1, lead} = sside;

  // rotate stage A: x1
  logic               va_q, oa_q, la_q;
  logic signed [32:0] x1a_q;
  logic signed [31:0] ya_q, axa_q, aya_q;
  logic signed [15:0] ca_q, sa_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) va_q <= 1'b0;
    else         va_q <= sv;
  end
  always_ff @(posedge clk_i) begin
    x1a_q <= 33'(lead) - 33'(root);
    ya_q <= y1; axa_q <= ax; aya_q <= ay;
    ca_q <= cs; sa_q <= sn; oa_q <= outside; la_q <= last;
  end

  // stage B: four products
  logic               vb_q, ob_q, lb_q;
  logic signed [48:0] xc_q, xs_q, yc_q, ys_q;
  logic signed [31:0] axb_q, ayb_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vb_q <= 1'b0;
    else         vb_q <= va_q;
  end
  always_ff @(posedge clk_i) begin
    xc_q <= 49'(x1a_q) * 49'(ca_q);
    xs_q <= 49'(x1a_q) * 49'(sa_q);
    yc_q <= 49'(ya_q) * 49'(ca_q);
    ys_q <= 49'(ya_q) * 49'(sa_q);
    axb_q <= axa_q; ayb_q <= aya_q; ob_q <= oa_q; lb_q <= la_q;
  end

  // stage C: sums with rounding and shift
  logic               vc_q, oc_q, lc_q;
  logic signed [50:0] sx_d, sy_d;
  logic signed [36:0] rx_q, ry_q;
  logic signed [31:0] axc_q, ayc_q;
  assign sx_d = 51'(xc_q) - 51'(ys_q) + 51'sd8192;
  assign sy_d = 51'(xs_q) + 51'(yc_q) + 51'sd8192;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vc_q <= 1'b0;
    else         vc_q <= vb_q;
  end
  always_ff @(posedge clk_i) begin
    rx_q <= sx_d[50:14];
    ry_q <= sy_d[50:14];
    axc_q <= axb_q; ayc_q <= ayb_q; oc_q <= ob_q; lc_q <= lb_q;
  end

  // stage D: add centre (or keep moved position) and saturate
  logic signed [37:0] ox_d, oy_d;
  logic signed [31:0] nx_d, ny_d;
  always_comb begin
    ox_d = 38'(rx_q) + 38'(axc_q);
    oy_d = 38'(ry_q) + 38'(ayc_q);
    nx_d = axc_q;
    ny_d = ayc_q;
    if (oc_q) begin
      if (ox_d > 38'sh0_7FFF_FFFF)       nx_d = 32'sh7FFF_FFFF;
      else if (ox_d < -38'sh0_8000_0000) nx_d = 32'sh8000_0000;
      else                                nx_d = ox_d[31:0];
      if (oy_d > 38'sh0_7FFF_FFFF)       ny_d = 32'sh7FFF_FFFF;
      else if (oy_d < -38'sh0_8000_0000) ny_d = 32'sh8000_0000;
      else                                ny_d = oy_d[31:0];
    end
  end

  logic               vd_q;
  dfms_pkg::dot_res_t res_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vd_q <= 1'b0;
    else         vd_q <= vc_q;
  end
  always_ff @(posedge clk_i) begin
    res_q.new_x      <= nx_d;
    res_q.new_y      <= ny_d;
    res_q.respawned  <= oc_q;
    res_q.frame_done <= lc_q;
  end

  assign res_valid_o = vd_q;
  assign res_o       = res_q;
endmodule

[design/dfms_checker.sv]
// Port-level checker for the dot field motion step unit, bound to the top.
// Uses dfms_pkg.
module dfms_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               res_valid_o,
  input dfms_pkg::dot_res_t res_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy raised");
  a_no_res_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !res_valid_o) else $error("result right after reset");
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##(dfms_pkg::PipeDepth) res_valid_o)
    else $error("result missing after request");
  a_flags_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !$isunknown({res_o.respawned, res_o.frame_done}))
    else $error("unknown flags");
endmodule

bind dot_field_motion_step_unit dfms_checker u_dfms_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .res_valid_o, .res_o
);

[verif/dot_field_motion_step_unit_tb.sv]
// Testbench for the dot field motion step unit: random and directed dot updates
// checked against an in-bench fixed-point predictor. Depends on dfms_pkg and the RTL.
module dot_field_motion_step_unit_tb;
  import dfms_pkg::*;

  // Expected-result store and checker.
  class dot_scoreboard;
    dot_res_t pending_q[$];
    int errors;

    function void note_request(dot_res_t r);
      pending_q = {pending_q, r};
    endfunction

    function void check_result(dot_res_t got);
      dot_res_t exp_r;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result x=%h y=%h", $time, got.new_x, got.new_y);
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      if (got.new_x !== exp_r.new_x) begin
        $display("%0t: new_x exp %h got %h", $time, exp_r.new_x, got.new_x);
        errors++;
      end
      if (got.new_y !== exp_r.new_y) begin
        $display("%0t: new_y exp %h got %h", $time, exp_r.new_y, got.new_y);
        errors++;
      end
      if (got.respawned !== exp_r.respawned) begin
        $display("%0t: respawned exp %b got %b", $time, exp_r.respawned, got.respawned);
        errors++;
      end
      if (got.frame_done !== exp_r.frame_done) begin
        $display("%0t: frame_done exp %b got %b", $time, exp_r.frame_done, got.frame_done);
        errors++;
      end
    endfunction
  endclass

  localparam int unsigned Latency  = 39;
  localparam int unsigned StallMax = 2000;

  logic clk_i, rst_ni;
  logic start_i, busy_o, res_valid_o;
  dot_req_t req_i;
  dot_res_t res_o;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0] cfg_data_i;

  dot_scoreboard sb;
  int idle_cycles;
  bit no_idle;  // stretch with no gaps between requests

  // Shadow copy of the config registers.
  logic [30:0]        radius_q;
  logic signed [31:0] cx_q, cy_q;

  dot_field_motion_step_unit DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .req_i, .res_valid_o, .res_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned a);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > a) bitv >>= 2;
    while (bitv != 0) begin
      if (a >= res + bitv) begin
        a -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Moves one dot; re-places it at the trailing edge when it leaves the circle.
  function automatic dot_res_t predict_dot(dot_req_t q);
    dot_res_t r;
    longint rad, px, py, dx, dy, y1, s, lead, x1, rx, ry, cs, sn;
    longint unsigned r2, mx, my, yy, arg;
    bit outside;
    rad = longint'(radius_q);
    r2 = longint'(rad) * rad;
    px = clamp32(longint'(q.pos_x) + longint'(q.step_x));
    py = clamp32(longint'(q.pos_y) + longint'(q.step_y));
    dx = px - longint'(cx_q);
    dy = py - longint'(cy_q);
    mx = dx < 0 ? -dx : dx;
    my = dy < 0 ? -dy : dy;
    outside = (mx > rad) || (my > rad);
    if (!outside) outside = (mx * mx + my * my) > r2;
    if (outside) begin
      cs = longint'(q.cos_dir);
      sn = longint'(q.sin_dir);
      y1 = -rad + longint'((longint'(q.rand_u) * (2 * rad)) >>> 16);
      yy = (y1 < 0 ? -y1 : y1) * (y1 < 0 ? -y1 : y1);
      arg = (r2 > yy) ? r2 - yy : 0;
      s = longint'(root64(arg));
      lead = (longint'(q.rand_v) * longint'(q.step_len)) >>> 16;
      x1 = lead - s;
      rx = (x1 * cs - y1 * sn + 8192) >>> 14;  // arithmetic shift = floor
      ry = (x1 * sn + y1 * cs + 8192) >>> 14;
      px = clamp32(rx + longint'(cx_q));
      py = clamp32(ry + longint'(cy_q));
    end
    r.new_x = px[31:0];
    r.new_y = py[31:0];
    r.respawned = outside;
    r.frame_done = q.last_dot;
    return r;
  endfunction

  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CfgRadius:  radius_q = val[30:0];
      CfgCenterX: cx_q = val;
      CfgCenterY: cy_q = val;
      default: ;
    endcase
  endtask

  // Drive one request at the falling edge; hold until taken.
  task automatic send_dot(dot_req_t q);
    if (!no_idle) begin
      while ($urandom_range(99) < 23) begin
        @(negedge clk_i);
        start_i = 1'b0;
      end
    end
    start_i = 1'b1;
    req_i = q;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(predict_dot(q));
    @(negedge clk_i);
    start_i = 1'b0;
  endtask

  // Wait for the pipe to drain before touching registers.
  task automatic drain;
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
    repeat (Latency + 5) @(negedge clk_i);
  endtask

  // Random coordinates and steps: mostly small frame motion, sometimes extreme.
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(65536 * 4) - 65536 * 2;
    endcase
  endfunction

  function automatic logic [15:0] rand_trig();
    if ($urandom_range(15) == 0) return $urandom();
    return $urandom_range(32768) - 16384;
  endfunction

  function automatic dot_req_t rand_dot();
    dot_req_t q;
    q.pos_x = $signed(cx_q) + $signed(rand_coord());
    q.pos_y = $signed(cy_q) + $signed(rand_coord());
    if ($urandom_range(7) == 0) q.pos_x = $urandom();
    q.step_x = $urandom_range(3) == 0 ? rand_coord() : $urandom_range(8192) - 4096;
    q.step_y = $urandom_range(3) == 0 ? rand_coord() : $urandom_range(8192) - 4096;
    q.step_len = $urandom_range(7) == 0 ? $urandom() : $urandom_range(16384);
    q.cos_dir = rand_trig();
    q.sin_dir = rand_trig();
    q.rand_u = $urandom();
    q.rand_v = $urandom();
    q.last_dot = $urandom_range(15) == 0;
    return q;
  endfunction

  // Result monitor: sample at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_result(res_o);
  end

  // Watchdog: cycles with no request, no result taken and no config write.
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || res_valid_o || cfg_we_i) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallMax) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    dot_req_t q;
    logic [31:0] radii[4];
    logic [31:0] centers[4];
    sb = new();
    idle_cycles = 0;
    no_idle = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CfgRadius;
    cfg_data_i = '0;
    radius_q = 31'd65536;
    cx_q = '0;
    cy_q = '0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: reset registers, on-circle, extremes, zero step, odd trig.
    q = '0;
    q.cos_dir = 16'sd16384;
    send_dot(q);                                  // at centre, stays
    q.pos_x = 32'sd65536; send_dot(q);           // exactly on circle
    q.pos_x = 32'sd65537; q.rand_u = 16'hFFFF; q.rand_v = 16'hFFFF;
    q.step_len = 31'h7FFF_FFFF; q.last_dot = 1'b1;
    send_dot(q);                                  // just outside
    q = '0;
    q.pos_x = 32'h7FFF_FFFF; q.step_x = 32'h7FFF_FFFF;
    q.pos_y = 32'h8000_0000; q.step_y = 32'h8000_0000;
    q.cos_dir = 16'h7FFF; q.sin_dir = 16'h8000;   // beyond unit range
    q.rand_u = 16'hFFFF;
    send_dot(q);
    q.rand_u = 16'h8000; q.cos_dir = -16'sd16384; q.sin_dir = 16'sd16384;
    send_dot(q);
    q.cos_dir = 16'sd0; q.sin_dir = -16'sd16384; q.step_len = 31'd65536;
    q.rand_v = 16'h8000; q.last_dot = 1'b1;
    send_dot(q);

    // Several register settings, extremes among them.
    radii = '{32'h7FFF_FFFF, 32'd1, 32'd0, 32'd196608};
    centers = '{32'h7FFF_FFFF, 32'h8000_0000, 32'sd123456, 32'd0};
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      if (ph < 4) begin
        write_cfg(CfgRadius, radii[ph]);
        write_cfg(CfgCenterX, centers[ph]);
        write_cfg(CfgCenterY, centers[3 - ph]);
        if (ph == 2) write_cfg(2'd3, 32'hFFFF_FFFF);  // unused index, ignored
      end else begin
        write_cfg(CfgRadius, 32'd65536 * ($urandom_range(200) + 1));
        write_cfg(CfgCenterX, $urandom_range(65536 * 100) - 65536 * 50);
        write_cfg(CfgCenterY, $urandom_range(65536 * 100) - 65536 * 50);
      end
      // Directed per phase: dot sitting on the centre and a far-away one.
      q = '0;
      q.pos_x = cx_q; q.pos_y = cy_q; q.cos_dir = 16'sd16384;
      send_dot(q);
      q.pos_x = ~cx_q; q.rand_u = 16'hFFFF; q.rand_v = 16'hFFFF; q.step_len = '1;
      send_dot(q);
      for (int n = 0; n < 260; n++) begin
        no_idle = (n >= 100 && n < 160);
        send_dot(rand_dot());
      end
      no_idle = 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
